// ----- hdl/kmer_count_histogram_top_defines.svh -----
// Assertion macros used by the checker file of this block.
`ifndef KMER_COUNT_HISTOGRAM_TOP_DEFINES_SVH
`define KMER_COUNT_HISTOGRAM_TOP_DEFINES_SVH

// Checked at every edge once reset is released.
`define KCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define KCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/kch_pkg.sv -----
`default_nettype none
package kch_pkg;

  localparam int TABLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int FIELD_BITS   = 16;
  localparam int SYM_BITS     = 5;
  localparam int ALPHA_BITS   = 6;
  localparam int KLEN_BITS    = 5;
  localparam int HIST_DEPTH   = 16;
  localparam int HIST_BITS    = 4;
  localparam int WCNT_BITS    = 4;
  localparam int ADDR_BITS    = 3;
  localparam int REG_IDX_BITS = 1;
  localparam int DATA_BITS    = 32;

  localparam logic [REG_IDX_BITS-1:0] REG_ALPHA_BASE = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_KMER_LEN   = 1'b1;

  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 6'd4;
  localparam logic [KLEN_BITS-1:0]  KLEN_RESET  = 5'd4;
  localparam logic [ALPHA_BITS-1:0] ALPHA_MIN   = 6'd2;
  localparam logic [ALPHA_BITS-1:0] ALPHA_MAX   = 6'd32;
  localparam logic [KLEN_BITS-1:0]  KLEN_MIN    = 5'd2;
  localparam logic [KLEN_BITS-1:0]  KLEN_MAX    = 5'd16;

  localparam logic MODE_FEED = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic [ALPHA_BITS-1:0] alpha_base;
    logic [KLEN_BITS-1:0]  kmer_len;
    logic                  written;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic calc;
    logic step;
    logic fetch;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic weight_busy;
    logic in_read;
    logic in_bad;
    logic will_count;
    logic out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ----- hdl/kch_ifs.sv -----
`default_nettype none
interface kch_feed_if
  import kch_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [SYM_BITS-1:0]   symbol;
  logic                  seq_end;
  logic [FIELD_BITS-1:0] read_index;

  modport source (output valid, mode, symbol, seq_end, read_index, input ready);
  modport sink (input valid, mode, symbol, seq_end, read_index, output ready);
endinterface

interface kch_res_if
  import kch_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  kmer_valid;
  logic [FIELD_BITS-1:0] kmer_index;
  logic [FIELD_BITS-1:0] count;
  logic [FIELD_BITS-1:0] kmers_in_seq;
  logic                  bad_symbol;

  modport source (output valid, kmer_valid, kmer_index, count, kmers_in_seq, bad_symbol,
                  input ready);
  modport sink (input valid, kmer_valid, kmer_index, count, kmers_in_seq, bad_symbol,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/kch_cfg.sv -----
`default_nettype none
module kch_cfg
  import kch_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic [ALPHA_BITS-1:0]   alpha_base;
  logic [KLEN_BITS-1:0]    kmer_len;
  logic                    write;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign write   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_BITS-1 -: REG_IDX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_base <= ALPHA_RESET;
      kmer_len   <= KLEN_RESET;
    end else if (write) begin
      case (reg_idx)
        REG_ALPHA_BASE: alpha_base <= pwdata[ALPHA_BITS-1:0];
        REG_KMER_LEN:   kmer_len   <= pwdata[KLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ALPHA_BASE: prdata = DATA_BITS'(alpha_base);
      REG_KMER_LEN:   prdata = DATA_BITS'(kmer_len);
      default:        prdata = '0;
    endcase
  end

  assign cfg.alpha_base = alpha_base;
  assign cfg.kmer_len   = kmer_len;
  assign cfg.written    = write;

endmodule
`default_nettype wire

// ----- hdl/kch_ctrl.sv -----
`default_nettype none
module kch_ctrl
  import kch_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_STEP   = 6'b001000,
    ST_FETCH  = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE) && !stat.weight_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (stat.in_read) begin
            state_next = ST_FETCH;
          end else if (stat.in_bad) begin
            state_next = ST_UPDATE;
          end else begin
            state_next = ST_CALC;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = stat.will_count ? ST_FETCH : ST_UPDATE;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/kch_datapath.sv -----
`default_nettype none
module kch_datapath
  import kch_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  cfg_t                       cfg,
  input  wire logic                  mode,
  input  wire logic [SYM_BITS-1:0]   symbol,
  input  wire logic                  seq_end,
  input  wire logic [FIELD_BITS-1:0] read_index,
  kch_res_if.source                  result,
  input  ctrl_cmd_t                  cmd,
  output ctrl_stat_t                 stat
);

  localparam int TABLE_DEPTH = 2 ** TABLE_BITS;

  logic [COUNT_BITS-1:0] mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] count_inc;
  logic [TABLE_BITS-1:0] clr_addr;

  logic [ALPHA_BITS-1:0] eff_a;
  logic [KLEN_BITS-1:0]  eff_k;

  logic                  wstart;
  logic [WCNT_BITS-1:0]  wcnt;
  logic [TABLE_BITS-1:0] top_weight;
  logic [TABLE_BITS+ALPHA_BITS-1:0] wprod;

  logic [TABLE_BITS-1:0] window_index;
  logic [KLEN_BITS-1:0]  fill;
  logic [FIELD_BITS-1:0] total;
  logic [FIELD_BITS-1:0] total_next;
  logic [SYM_BITS-1:0]   hist [HIST_DEPTH];
  logic [SYM_BITS-1:0]   oldest;

  logic                  l_read;
  logic [SYM_BITS-1:0]   l_sym;
  logic                  l_end;
  logic                  l_bad;
  logic                  counted;
  logic [TABLE_BITS-1:0] cur_index;
  logic [TABLE_BITS-1:0] part;
  logic [TABLE_BITS+SYM_BITS-1:0]   oprod;
  logic [TABLE_BITS+ALPHA_BITS-1:0] sprod;
  logic                  touched;

  logic                  res_valid;
  logic                  o_kmer_valid;
  logic [FIELD_BITS-1:0] o_kmer_index;
  logic [FIELD_BITS-1:0] o_count;
  logic [FIELD_BITS-1:0] o_total;
  logic                  o_bad;

  always_comb begin
    if (cfg.alpha_base < ALPHA_MIN) begin
      eff_a = ALPHA_MIN;
    end else if (cfg.alpha_base > ALPHA_MAX) begin
      eff_a = ALPHA_MAX;
    end else begin
      eff_a = cfg.alpha_base;
    end
    if (cfg.kmer_len < KLEN_MIN) begin
      eff_k = KLEN_MIN;
    end else if (cfg.kmer_len > KLEN_MAX) begin
      eff_k = KLEN_MAX;
    end else begin
      eff_k = cfg.kmer_len;
    end
  end

  // The top weight is A to the power k-1, built one multiplication per cycle.
  assign wprod = top_weight * eff_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      wstart <= 1'b1;
      wcnt   <= '0;
    end else if (cfg.written) begin
      wstart <= 1'b1;
      wcnt   <= '0;
    end else if (wstart) begin
      wstart     <= 1'b0;
      top_weight <= TABLE_BITS'(1);
      wcnt       <= WCNT_BITS'(eff_k - KLEN_BITS'(1));
    end else if (wcnt != '0) begin
      top_weight <= wprod[TABLE_BITS-1:0];
      wcnt       <= wcnt - WCNT_BITS'(1);
    end
  end

  assign oldest  = hist[HIST_BITS'(eff_k - KLEN_BITS'(1))];
  assign oprod   = top_weight * oldest;
  assign sprod   = part * eff_a + (TABLE_BITS + ALPHA_BITS)'(l_sym);
  assign touched = l_read || counted;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_read <= mode;
      l_sym  <= symbol;
      l_end  <= seq_end;
      l_bad  <= (mode == MODE_FEED) && stat.in_bad;
      if (mode == MODE_READ) begin
        cur_index <= TABLE_BITS'(read_index);
      end
    end
    if (cmd.calc) begin
      part <= (fill >= eff_k) ? window_index - oprod[TABLE_BITS-1:0] : window_index;
    end
    if (cmd.step) begin
      cur_index <= sprod[TABLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counted <= 1'b0;
    end else if (cmd.load) begin
      counted <= 1'b0;
    end else if (cmd.step) begin
      counted <= stat.will_count;
    end
  end

  assign total_next = (counted && total != '1) ? total + FIELD_BITS'(1) : total;

  always_ff @(posedge clk) begin
    if (rst || cfg.written) begin
      window_index <= '0;
      fill         <= '0;
      total        <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (cmd.step) begin
      window_index <= sprod[TABLE_BITS-1:0];
      if (fill < eff_k) begin
        fill <= fill + KLEN_BITS'(1);
      end
      hist[0] <= l_sym;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end else if (cmd.finish) begin
      if (!l_read && l_end) begin
        window_index <= '0;
        fill         <= '0;
        total        <= '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
          hist[i] <= '0;
        end
      end else begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + TABLE_BITS'(1);
    end
  end

  assign count_inc = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
  assign wr_data   = l_read ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= '0;
    end else if (cmd.finish && touched) begin
      mem[cur_index] <= wr_data;
    end
    if (cmd.fetch) begin
      rd_data <= mem[cur_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_kmer_valid <= counted;
      o_kmer_index <= touched ? FIELD_BITS'(cur_index) : '0;
      o_count      <= !touched ? '0 : (l_read ? FIELD_BITS'(rd_data) : FIELD_BITS'(count_inc));
      o_total      <= l_read ? total : total_next;
      o_bad        <= l_bad;
    end
  end

  assign result.valid        = res_valid;
  assign result.kmer_valid   = o_kmer_valid;
  assign result.kmer_index   = o_kmer_index;
  assign result.count        = o_count;
  assign result.kmers_in_seq = o_total;
  assign result.bad_symbol   = o_bad;

  assign stat.clear_last  = &clr_addr;
  assign stat.weight_busy = wstart || (wcnt != '0);
  assign stat.in_read     = (mode == MODE_READ);
  assign stat.in_bad      = ({1'b0, symbol} >= eff_a);
  assign stat.will_count  = ({1'b0, fill} + (KLEN_BITS + 1)'(1)) >= {1'b0, eff_k};
  assign stat.out_free    = !res_valid || result.ready;

endmodule
`default_nettype wire

// ----- hdl/kmer_count_histogram_top.sv -----
// Channel   Role      Word
// feed      sink      mode, symbol, seq_end, read_index
// result    source    kmer_valid, kmer_index, count, kmers_in_seq, bad_symbol
// config    APB       alpha_base at 0x0, kmer_len at 0x4
//
// A symbol that completes a k-mer takes accept, two multiply steps, histogram
// read and write; one that does not skips the read, a bad symbol goes from
// accept to write, and a read-and-clear skips both multiply steps; the single-port
// histogram read-modify-write sets this order. After reset the histogram is
// cleared one entry a cycle, during which no word is accepted; a register write
// recomputes the top weight. A stalled result holds the last step until taken.
`default_nettype none
module kmer_count_histogram_top
  import kch_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  kch_feed_if.sink                  feed,
  kch_res_if.source                 result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  kch_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (feed.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kch_datapath #(
    .TABLE_BITS (TABLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .mode       (feed.mode),
    .symbol     (feed.symbol),
    .seq_end    (feed.seq_end),
    .read_index (feed.read_index),
    .result     (result),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
`default_nettype wire

// ----- hdl/kch_checker.sv -----
`default_nettype none
`include "kmer_count_histogram_top_defines.svh"
module kch_checker
  import kch_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  kmer_valid,
  input wire logic [FIELD_BITS-1:0] kmer_index,
  input wire logic [FIELD_BITS-1:0] count,
  input wire logic [FIELD_BITS-1:0] kmers_in_seq,
  input wire logic                  bad_symbol
);

  `KCH_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result word present after reset")
  `KCH_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second word taken while busy")
  `KCH_ASSERT(a_bad_clean, out_valid && bad_symbol |-> !kmer_valid && kmer_index == '0 && count == '0, "bad symbol word carries a k-mer")
  `KCH_ASSERT(a_total_counts, out_valid && kmer_valid |-> kmers_in_seq != '0 && count != '0, "counted k-mer with zero totals")
  `KCH_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(count) && $stable(kmer_index) && $stable(kmers_in_seq), "stalled result word changed")

endmodule

bind kmer_count_histogram_top kch_checker u_kch_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (feed.valid),
  .in_ready     (feed.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .kmer_valid   (result.kmer_valid),
  .kmer_index   (result.kmer_index),
  .count        (result.count),
  .kmers_in_seq (result.kmers_in_seq),
  .bad_symbol   (result.bad_symbol)
);
`default_nettype wire
